// File: rtl/core/block_chain_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block chain allocator
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH
`define BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("block chain allocator: same-cycle check failed");

// next-cycle implication
`define BCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("block chain allocator: next-cycle check failed");

`else

`define BCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Widths, codes and controller states of the block chain allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

	localparam int OP_W   = 3;
	localparam int BLK_W  = 16;
	localparam int CNT_W  = 13;
	localparam int STAT_W = 2;

	localparam int DEF_TABLE_DEPTH = 4096;
	localparam int RESET_BLOCKS    = 4096;
	localparam int MIN_BLOCKS      = 2;

	localparam logic [BLK_W-1:0] END_MARK  = 16'hFFFF;
	localparam logic [BLK_W-1:0] FREE_MARK = 16'h0000;

	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
	localparam logic [OP_W-1:0] OP_SET     = 3'd2;
	localparam logic [OP_W-1:0] OP_GET     = 3'd3;
	localparam logic [OP_W-1:0] OP_EXTEND  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LINK_WR,
		S_REL_RD,
		S_REL_CHK,
		S_LINK_CHK
	} bca_state_t;

endpackage

// File: rtl/core/bca_ram.sv
// ----------------------------------------------------------------------------
// bca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/block_chain_allocator.sv
// ----------------------------------------------------------------------------
// block_chain_allocator
// Set next, range errors, empty releases and full hits finish with no table
// read; get next and extend on a link after one read; release frees each link
// in turn; allocate scans from the hint to a free block, then on to the next
// free one for the new hint; extend at an end marker allocates too. One
// transaction at a time. Reset and each config write run a clearing pass
// over the table (busy high). done, a one-cycle strobe, cannot be stalled.
// ----------------------------------------------------------------------------
`include "block_chain_allocator_assert.svh"

module block_chain_allocator #(
	parameter int TABLE_DEPTH = bca_pkg::DEF_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [bca_pkg::OP_W-1:0]    op,
	input  logic [bca_pkg::BLK_W-1:0]   block,
	input  logic [bca_pkg::BLK_W-1:0]   next_value,
	// result strobe
	output logic                        done,
	output logic [bca_pkg::BLK_W-1:0]   result_block,
	output logic [bca_pkg::CNT_W-1:0]   free_blocks,
	output logic [bca_pkg::STAT_W-1:0]  status,
	// blocks_in_use register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bca_pkg::CNT_W-1:0]   cfg_data
);

	import bca_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	// managed block count after reset, clamped to the table
	localparam logic [CNT_W-1:0] N_RST =
		CNT_W'((RESET_BLOCKS > TABLE_DEPTH) ? TABLE_DEPTH : RESET_BLOCKS);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	bca_state_t state_q, state_d;

	logic              done_q;
	logic [CNT_W-1:0]  n_q;           // managed blocks N (clamped)
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  first_free_q;  // N means no free block known
	logic [AW-1:0]     clr_q;         // clearing pass address
	logic              chk_vld_q;     // a scan read is in flight
	logic              hint_ph_q;     // scan phase: 0 take block, 1 new hint

	// per-transaction registers
	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  blk_q;
	logic [CNT_W-1:0]  pos_q;         // release walk position
	logic [CNT_W-1:0]  steps_q;       // release walk step count
	logic [CNT_W-1:0]  iss_q;         // next scan address to read
	logic [CNT_W-1:0]  chk_q;         // address of the data now on rdata
	logic [CNT_W-1:0]  fnd_q;         // block taken by this transaction
	logic [BLK_W-1:0]  result_q;
	logic [STAT_W-1:0] status_q;

	// table RAM port
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BLK_W-1:0]  mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [BLK_W-1:0]  rdata;

	// result of the current cycle, registered into the strobe
	logic              fin;
	logic [BLK_W-1:0]  fin_res;
	logic [STAT_W-1:0] fin_stat;

	// ------------------------------------------------------------------
	// Decode
	// ------------------------------------------------------------------
	logic             accept;
	logic             cfg_fire;
	logic [CNT_W-1:0] n_cfg;
	logic             blk_big;
	logic             blk_nil;
	logic             fc_zero;
	logic             rd_free;
	logic             rd_end;
	logic             nx_big;
	logic             iss_ok;
	logic             scan_hit;
	logic             scan_miss;
	logic [CNT_W-1:0] steps_nx;
	logic             steps_out;
	logic             rel_stop;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start & ~busy;

	// blocks_in_use is clamped to [2, TABLE_DEPTH] when written
	assign n_cfg = (cfg_data < CNT_W'(MIN_BLOCKS)) ? CNT_W'(MIN_BLOCKS) :
		((17'(cfg_data) > DEPTH_L) ? CNT_W'(DEPTH_L) : cfg_data);

	assign blk_big = (block >= BLK_W'(n_q));
	assign blk_nil = (block == FREE_MARK) || (block == END_MARK);
	assign fc_zero = (free_count_q == '0);
	assign rd_free = (rdata == FREE_MARK);
	assign rd_end  = (rdata == END_MARK);
	assign nx_big  = (rdata >= BLK_W'(n_q));

	// forward scan: one read issued per cycle, checked the cycle after
	assign iss_ok    = (iss_q < n_q);
	assign scan_hit  = chk_vld_q & rd_free;
	assign scan_miss = ~scan_hit & ~iss_ok;

	// release walk stops at a free entry, after N steps, at the end marker,
	// or at a link beyond the managed range
	assign steps_nx  = steps_q + 1'b1;
	assign steps_out = (steps_nx >= n_q);
	assign rel_stop  = rd_free | steps_out | rd_end | nx_big;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_ALLOC:   state_d = fc_zero ? S_IDLE : S_SCAN;
						OP_RELEASE: state_d = (blk_nil | blk_big) ? S_IDLE : S_REL_CHK;
						OP_GET:     state_d = blk_big ? S_IDLE : S_LINK_CHK;
						OP_EXTEND:  state_d = blk_big ? S_IDLE : S_LINK_CHK;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_LINK_CHK: begin
				if ((op_q == OP_GET) | ~rd_end | fc_zero) state_d = S_IDLE;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (!hint_ph_q) begin
					if (scan_hit) state_d = (op_q == OP_EXTEND) ? S_LINK_WR : S_SCAN;
					else if (scan_miss) state_d = S_IDLE;
				end else if (scan_hit | scan_miss) begin
					state_d = S_IDLE;
				end
			end
			S_LINK_WR: state_d = S_SCAN;
			S_REL_RD:  state_d = S_REL_CHK;
			S_REL_CHK: state_d = rel_stop ? S_IDLE : S_REL_RD;
			default:   state_d = S_IDLE;
		endcase
		if (cfg_fire) state_d = S_CLEAR;
	end

	// ------------------------------------------------------------------
	// RAM port and result decode
	// ------------------------------------------------------------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = FREE_MARK;
		mem_raddr = AW'(iss_q);
		fin       = 1'b0;
		fin_res   = '0;
		fin_stat  = STAT_OK;
		case (state_q)
			S_CLEAR: begin
				// entry 0 is the reserved end of chain
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? END_MARK : FREE_MARK;
			end
			S_IDLE: begin
				mem_raddr = AW'(block);
				if (accept) begin
					case (op)
						OP_ALLOC: begin
							if (fc_zero) begin
								fin      = 1'b1;
								fin_stat = STAT_FULL;
							end
						end
						OP_RELEASE: begin
							if (blk_nil) begin
								fin = 1'b1;
							end else if (blk_big) begin
								fin      = 1'b1;
								fin_stat = STAT_RANGE;
							end
						end
						OP_SET: begin
							fin = 1'b1;
							if (blk_big) begin
								fin_stat = STAT_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(block);
								mem_wdata = next_value;
							end
						end
						OP_GET, OP_EXTEND: begin
							if (blk_big) begin
								fin      = 1'b1;
								fin_stat = STAT_RANGE;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_LINK_CHK: begin
				if ((op_q == OP_GET) | ~rd_end) begin
					fin     = 1'b1;
					fin_res = rdata;
				end else if (fc_zero) begin
					fin      = 1'b1;
					fin_stat = STAT_FULL;
				end
			end
			S_SCAN: begin
				if (!hint_ph_q) begin
					if (scan_hit) begin
						mem_we    = 1'b1;
						mem_waddr = AW'(chk_q);
						mem_wdata = END_MARK;
					end else if (scan_miss) begin
						fin      = 1'b1;
						fin_stat = STAT_FULL;
					end
				end else if (scan_hit | scan_miss) begin
					fin     = 1'b1;
					fin_res = BLK_W'(fnd_q);
				end
			end
			S_LINK_WR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(blk_q);
				mem_wdata = BLK_W'(fnd_q);
			end
			S_REL_RD: begin
				mem_raddr = AW'(pos_q);
			end
			S_REL_CHK: begin
				if (!rd_free) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pos_q);
					mem_wdata = FREE_MARK;
				end
				if (rel_stop) begin
					fin = 1'b1;
					if (~rd_free & ~steps_out & ~rd_end & nx_big) fin_stat = STAT_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			done_q       <= 1'b0;
			n_q          <= N_RST;
			free_count_q <= N_RST - 1'b1;
			first_free_q <= CNT_W'(1);
			clr_q        <= '0;
			chk_vld_q    <= 1'b0;
			hint_ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin & ~cfg_fire;
			if (cfg_fire) begin
				// reformat with the new block count
				n_q          <= n_cfg;
				free_count_q <= n_cfg - 1'b1;
				first_free_q <= CNT_W'(1);
				clr_q        <= '0;
			end else begin
				case (state_q)
					S_CLEAR: clr_q <= clr_q + 1'b1;
					S_IDLE: begin
						if (accept && (op == OP_ALLOC) && !fc_zero) begin
							chk_vld_q <= 1'b0;
							hint_ph_q <= 1'b0;
						end
					end
					S_LINK_CHK: begin
						chk_vld_q <= 1'b0;
						hint_ph_q <= 1'b0;
					end
					S_SCAN: begin
						if (!hint_ph_q && scan_hit) begin
							free_count_q <= free_count_q - 1'b1;
							chk_vld_q    <= 1'b0;
							hint_ph_q    <= 1'b1;
						end else if (hint_ph_q && scan_hit) begin
							first_free_q <= chk_q;
						end else if (hint_ph_q && scan_miss) begin
							first_free_q <= n_q;
						end else begin
							chk_vld_q <= iss_ok;
						end
					end
					S_REL_CHK: begin
						if (!rd_free) begin
							if (free_count_q < n_q - 1'b1) free_count_q <= free_count_q + 1'b1;
							if (pos_q < first_free_q) first_free_q <= pos_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Transaction payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= op;
					blk_q   <= CNT_W'(block);
					pos_q   <= CNT_W'(block);
					steps_q <= '0;
					iss_q   <= first_free_q;
				end
			end
			S_LINK_CHK: iss_q <= first_free_q;
			S_SCAN: begin
				if (!hint_ph_q && scan_hit) begin
					// hint search restarts just past the taken block
					fnd_q <= chk_q;
					iss_q <= chk_q + 1'b1;
				end else if (iss_ok) begin
					chk_q <= iss_q;
					iss_q <= iss_q + 1'b1;
				end
			end
			S_REL_CHK: begin
				pos_q   <= CNT_W'(rdata);
				steps_q <= steps_nx;
			end
			default: begin
			end
		endcase
		if (fin) begin
			result_q <= fin_res;
			status_q <= fin_stat;
		end
	end

	// ------------------------------------------------------------------
	// Link table
	// ------------------------------------------------------------------
	bca_ram #(
		.WIDTH (BLK_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign done         = done_q;
	assign result_block = result_q;
	assign status       = status_q;
	// the count only moves inside a transaction or on a config write, so it is final on the strobe
	assign free_blocks  = free_count_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BCA_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy)
	`BCA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, free_count_q <= n_q - 1'b1)
	`BCA_ASSERT_IMP(a_hint_nonzero, clk, arst_n, 1'b1, first_free_q != '0)
	`BCA_ASSERT_NXT(a_set_one_cycle, clk, arst_n, accept && (op == OP_SET) && !cfg_valid, done_q)

endmodule

// File: test/block_chain_allocator_test.sv
// ----------------------------------------------------------------------------
// block_chain_allocator_test
// Self-checking bench for the block chain allocator. A driver issues
// commands and blocks_in_use writes from a planned queue. A monitor keeps a
// shadow link table, forecasts each command's result when it is accepted
// and checks every done strobe against the oldest forecast.
// ----------------------------------------------------------------------------
module block_chain_allocator_test;

	import bca_pkg::*;

	// clock period 8, watchdog on accept-free stretches
	localparam int STALL_LIMIT = 40000;
	localparam int SETTLE      = 4;     // quiet cycles before a config write
	localparam int DRAIN       = 64;    // trailing cycles after the last result
	localparam int PHASE_ITEMS = 200;

	// op codes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	// where a planned command takes its block number from
	typedef enum logic [1:0] {
		FROM_FIELD,
		FROM_HEAD,
		FROM_TAIL
	} pick_t;

	typedef struct packed {
		logic             is_cfg;
		logic [CNT_W-1:0] cfg_val;
		logic [OP_W-1:0]  code;
		logic [BLK_W-1:0] blk;
		logic [BLK_W-1:0] nv;
		pick_t            blk_from;
		logic             nv_head;   // link value is the current chain head
	} plan_t;

	typedef struct packed {
		logic [BLK_W-1:0]  result_block;
		logic [CNT_W-1:0]  free_blocks;
		logic [STAT_W-1:0] status;
	} outcome_t;

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              busy;
	logic [OP_W-1:0]   op         = OP_ALLOC;
	logic [BLK_W-1:0]  block      = '0;
	logic [BLK_W-1:0]  next_value = '0;
	logic              done;
	logic [BLK_W-1:0]  result_block;
	logic [CNT_W-1:0]  free_blocks;
	logic [STAT_W-1:0] status;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data   = '0;

	block_chain_allocator #(
		.TABLE_DEPTH(DEF_TABLE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.block       (block),
		.next_value  (next_value),
		.done        (done),
		.result_block(result_block),
		.free_blocks (free_blocks),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the allocator: link table, hint, free count, managed size
	// ------------------------------------------------------------------
	logic [BLK_W-1:0] links [DEF_TABLE_DEPTH];
	int               n_used;
	int               hint;
	int               free_cnt;

	plan_t    command_plan[$];
	outcome_t pending_outcomes[$];

	int               mismatches = 0;
	int               quiet_cycles = 0;   // idle edges with nothing outstanding
	int               stall_cycles = 0;   // edges with no transaction at all
	logic [BLK_W-1:0] chain_head = 16'd1; // latest allocated chain start
	logic [BLK_W-1:0] chain_tail = 16'd1; // latest block appended to it

	// register write and reset both reformat the table; size clamps to range
	function automatic void format_links(input int setting);
		n_used = setting < MIN_BLOCKS ? MIN_BLOCKS :
			(setting > DEF_TABLE_DEPTH ? DEF_TABLE_DEPTH : setting);
		foreach (links[i])
			links[i] = FREE_MARK;
		links[0] = END_MARK;
		hint     = 1;
		free_cnt = n_used - 1;
	endfunction

	function automatic int first_free_from(input int from);
		for (int i = from; i < n_used; i++)
			if (links[i] == FREE_MARK)
				return i;
		return n_used;
	endfunction

	// claim the first free entry at or past the hint; a stale hint is skipped
	function automatic logic [STAT_W-1:0] claim_block(output int got);
		int f;
		got = 0;
		if (free_cnt == 0)
			return STAT_FULL;
		f = first_free_from(hint);
		if (f >= n_used)
			return STAT_FULL;
		links[f] = END_MARK;
		hint     = first_free_from(f + 1);
		free_cnt--;
		got = f;
		return STAT_OK;
	endfunction

	// walk a chain freeing entries; stops on end, entry 0, a free entry,
	// a step bound, or a link past the managed range
	function automatic logic [STAT_W-1:0] free_chain(input int pos);
		int steps;
		int nx;
		steps = 0;
		if (pos == END_MARK || pos == 0)
			return STAT_OK;
		if (pos >= n_used)
			return STAT_RANGE;
		while (steps < n_used) begin
			if (pos == END_MARK || pos == 0)
				break;
			if (pos >= n_used)
				return STAT_RANGE;
			nx = int'(links[pos]);
			if (nx == FREE_MARK)
				break;
			links[pos] = FREE_MARK;
			if (free_cnt < n_used - 1)
				free_cnt++;
			if (pos < hint)
				hint = pos;
			pos = nx;
			steps++;
		end
		return STAT_OK;
	endfunction

	// forecast one command and update the shadow table
	function automatic outcome_t apply_table_op(input logic [OP_W-1:0] code,
			input logic [BLK_W-1:0] blk, input logic [BLK_W-1:0] nv);
		outcome_t r;
		int       got;
		r.result_block = '0;
		r.status       = STAT_OK;
		case (code)
			OP_ALLOC: begin
				r.status       = claim_block(got);
				r.result_block = got[BLK_W-1:0];
			end
			OP_RELEASE: r.status = free_chain(int'(blk));
			OP_SET: begin
				if (blk >= n_used)
					r.status = STAT_RANGE;
				else
					links[blk] = nv;
			end
			OP_GET: begin
				if (blk >= n_used)
					r.status = STAT_RANGE;
				else
					r.result_block = links[blk];
			end
			OP_EXTEND: begin
				if (blk >= n_used) begin
					r.status = STAT_RANGE;
				end else if (links[blk] == END_MARK) begin
					r.status = claim_block(got);
					if (r.status == STAT_OK) begin
						links[blk]     = got[BLK_W-1:0];
						r.result_block = got[BLK_W-1:0];
					end
				end else begin
					r.result_block = links[blk];
				end
			end
			default: ;
		endcase
		r.free_blocks = free_cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic void flag_field(input string name, input logic [BLK_W-1:0] want,
			input logic [BLK_W-1:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, seen);
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: check results, then forecast the command accepted this edge
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t         want;
		logic             moved;
		logic [BLK_W-1:0] new_head;
		logic [BLK_W-1:0] new_tail;
		if (!arst_n) begin
			format_links(RESET_BLOCKS);
			pending_outcomes.delete();
			quiet_cycles <= 0;
			stall_cycles <= 0;
			chain_head   <= 16'd1;
			chain_tail   <= 16'd1;
		end else begin
			moved    = 1'b0;
			new_head = chain_head;
			new_tail = chain_tail;
			if (done) begin
				moved = 1'b1;
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result, block %0h count %0d status %0d",
							$realtime, result_block, free_blocks, status);
				end else begin
					want = pending_outcomes.pop_front();
					flag_field("result_block", want.result_block, result_block);
					flag_field("free_blocks", BLK_W'(want.free_blocks), BLK_W'(free_blocks));
					flag_field("status", BLK_W'(want.status), BLK_W'(status));
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				format_links(int'(cfg_data));
				new_head = 16'd1;
				new_tail = 16'd1;
			end
			if (start && !busy) begin
				moved = 1'b1;
				want  = apply_table_op(op, block, next_value);
				pending_outcomes.push_back(want);
				// remember live chains so later commands can build on them
				if (want.status == STAT_OK && op == OP_ALLOC) begin
					new_head = want.result_block;
					new_tail = want.result_block;
				end else if (want.status == STAT_OK && op == OP_EXTEND) begin
					new_tail = want.result_block;
				end
			end
			chain_head   <= new_head;
			chain_tail   <= new_tail;
			quiet_cycles <= (moved || pending_outcomes.size() != 0) ? 0 : quiet_cycles + 1;
			stall_cycles <= moved ? 0 : stall_cycles + 1;
		end
	end

	// nothing accepted for far longer than a full clear plus a full scan
	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[block_chain_allocator] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: issue planned transactions with random gaps
	// ------------------------------------------------------------------
	int gap_left  = 0;
	int calm_left = 0;   // run of back-to-back commands

	always @(posedge clk or negedge arst_n) begin : drive
		plan_t nxt;
		if (!arst_n) begin
			start      <= 1'b0;
			op         <= OP_ALLOC;
			block      <= '0;
			next_value <= '0;
			cfg_valid  <= 1'b0;
			cfg_data   <= '0;
			gap_left   <= 0;
			calm_left  <= 0;
		end else if ((start && busy) || (cfg_valid && !cfg_ready)) begin
			// transaction still offered
		end else if (gap_left != 0) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left  <= gap_left - 1;
		end else if (command_plan.size() != 0 && (!command_plan[0].is_cfg ||
				(!start && quiet_cycles >= SETTLE))) begin
			// a config write waits until the block has gone quiet
			nxt = command_plan.pop_front();
			if (nxt.is_cfg) begin
				start     <= 1'b0;
				cfg_valid <= 1'b1;
				cfg_data  <= nxt.cfg_val;
			end else begin
				cfg_valid  <= 1'b0;
				start      <= 1'b1;
				op         <= nxt.code;
				block      <= nxt.blk_from == FROM_HEAD ? chain_head :
					(nxt.blk_from == FROM_TAIL ? chain_tail : nxt.blk);
				next_value <= nxt.nv_head ? chain_head : nxt.nv;
			end
			if (calm_left != 0) begin
				calm_left <= calm_left - 1;
				gap_left  <= 0;
			end else if ($urandom_range(0, 9) == 0) begin
				calm_left <= $urandom_range(8, 40);
				gap_left  <= 0;
			end else begin
				gap_left  <= $urandom_range(0, 14);
			end
		end else begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	task automatic plan_cmd(input logic [OP_W-1:0] code, input logic [BLK_W-1:0] blk,
			input logic [BLK_W-1:0] nv, input pick_t from, input logic nv_head);
		plan_t p;
		p          = '0;
		p.code     = code;
		p.blk      = blk;
		p.nv       = nv;
		p.blk_from = from;
		p.nv_head  = nv_head;
		command_plan.push_back(p);
	endtask

	task automatic plan_cfg(input logic [CNT_W-1:0] val);
		plan_t p;
		p         = '0;
		p.is_cfg  = 1'b1;
		p.cfg_val = val;
		command_plan.push_back(p);
	endtask

	// one phase: a size setting, then mostly allocate/extend/release chains
	// with random corruption, the rest random noise
	task automatic plan_phase(input int setting, input int count);
		int               lim;
		int               made;
		int               hops;
		logic [OP_W-1:0]  code;
		logic [BLK_W-1:0] blk;
		logic [BLK_W-1:0] nv;
		lim  = setting < MIN_BLOCKS ? MIN_BLOCKS :
			(setting > DEF_TABLE_DEPTH ? DEF_TABLE_DEPTH : setting);
		made = 0;
		plan_cfg(CNT_W'(setting));
		while (made < count) begin
			if ($urandom_range(0, 9) < 6) begin
				plan_cmd(OP_ALLOC, BLK_W'($urandom), BLK_W'($urandom), FROM_FIELD, 1'b0);
				hops = $urandom_range(0, 6);
				repeat (hops)
					plan_cmd(OP_EXTEND, BLK_W'($urandom), BLK_W'($urandom), FROM_TAIL, 1'b0);
				made += hops + 1;
				case ($urandom_range(0, 5))
					0: plan_cmd(OP_SET, 0, 0, FROM_TAIL, 1'b1);  // close a loop
					1: plan_cmd(OP_SET, 0, BLK_W'($urandom_range(0, lim + 3)), FROM_TAIL,
						1'b0);
					2: plan_cmd(OP_GET, 0, BLK_W'($urandom), FROM_TAIL, 1'b0);
					3: plan_cmd(OP_EXTEND, 0, BLK_W'($urandom), FROM_HEAD, 1'b0);
					default: made--;
				endcase
				made++;
				// leave some chains allocated so the table can fill up
				if ($urandom_range(0, 9) < 7) begin
					plan_cmd(OP_RELEASE, 0, BLK_W'($urandom), FROM_HEAD, 1'b0);
					made++;
				end
			end else begin
				code = OP_W'($urandom_range(0, 7));
				case ($urandom_range(0, 3))
					0, 1: blk = BLK_W'($urandom_range(0, lim + 1));
					2:    blk = BLK_W'($urandom_range(0, 15));
					default: blk = BLK_W'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: nv = BLK_W'($urandom_range(0, lim + 1));
					1: nv = END_MARK;
					2: nv = FREE_MARK;
					default: nv = BLK_W'($urandom);
				endcase
				plan_cmd(code, blk, nv, FROM_FIELD, 1'b0);
				made++;
			end
		end
	endtask

	initial begin
		// directed: full-size table after reset
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);            // block 1
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);            // block 2
		plan_cmd(OP_EXTEND, 16'd1, 0, FROM_FIELD, 1'b0);       // 1 -> 3
		plan_cmd(OP_GET, 16'd1, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_SET, 16'd4, END_MARK, FROM_FIELD, 1'b0);   // hint goes stale
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);            // skips 4
		plan_cmd(OP_GET, 16'd4095, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_SET, 16'd4095, END_MARK, FROM_FIELD, 1'b0);
		plan_cmd(OP_GET, 16'd4096, 0, FROM_FIELD, 1'b0);       // out of range
		plan_cmd(OP_SET, 16'hFFFF, 16'hFFFF, FROM_FIELD, 1'b0);
		plan_cmd(OP_EXTEND, 16'hFFFF, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_EXTEND, 16'd2, 0, FROM_FIELD, 1'b0);       // allocates
		plan_cmd(OP_EXTEND, 16'd0, 0, FROM_FIELD, 1'b0);       // entry 0 holds end
		plan_cmd(OP_RELEASE, 16'd0, 0, FROM_FIELD, 1'b0);      // empty chains
		plan_cmd(OP_RELEASE, END_MARK, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_RELEASE, 16'd4096, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_RELEASE, 16'd1, 0, FROM_FIELD, 1'b0);      // frees 1 and 3
		plan_cmd(OP_SPARE_A, 16'hFFFF, 16'hFFFF, FROM_FIELD, 1'b0);
		plan_cmd(OP_SPARE_B, 16'd1, 16'd1, FROM_FIELD, 1'b0);
		plan_cmd(OP_SPARE_C, 16'd0, 16'd0, FROM_FIELD, 1'b0);
		plan_cmd(OP_SET, 16'd2, 16'd4100, FROM_FIELD, 1'b0);   // link past range
		plan_cmd(OP_RELEASE, 16'd2, 0, FROM_FIELD, 1'b0);
		// smallest table: one free block, then full
		plan_cfg('0);
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);
		plan_cmd(OP_EXTEND, 16'd1, 0, FROM_FIELD, 1'b0);
		// count nonzero but every entry taken by set next
		plan_cfg(13'd3);
		plan_cmd(OP_SET, 16'd1, 16'd9, FROM_FIELD, 1'b0);
		plan_cmd(OP_SET, 16'd2, 16'd9, FROM_FIELD, 1'b0);
		plan_cmd(OP_ALLOC, 0, 0, FROM_FIELD, 1'b0);

		// random phases across sizes, extremes included
		plan_phase(8191, PHASE_ITEMS);
		plan_phase(7, PHASE_ITEMS);
		plan_phase(16, PHASE_ITEMS);
		plan_phase(1, PHASE_ITEMS);
		plan_phase(40, PHASE_ITEMS);
		plan_phase(4096, PHASE_ITEMS);
		plan_phase(100, PHASE_ITEMS);
		plan_phase(3, PHASE_ITEMS);
		plan_phase(25, PHASE_ITEMS);
		plan_phase(2, PHASE_ITEMS);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so the drained state is settled
		while (command_plan.size() != 0 || start || cfg_valid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("[block_chain_allocator] OK");
		else
			$display("[block_chain_allocator] ERROR");
		$finish;
	end

endmodule
